// ===== design/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  // Port width of every payload field.
  localparam int unsigned FIELD_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } mexp_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               error;
  } mexp_out_t;

  // One step of the bit-serial modular multiplier.
  typedef struct packed {
    logic first;  // first step of a product: treat the remainder as zero
    logic add;    // add phase (else double phase)
  } mm_step_t;

  // Sequencer outputs toward the datapath.
  typedef struct packed {
    logic     idle;
    logic     load;
    logic     expo;
    logic     fin;
    logic     mul_last;
    mm_step_t step;
  } mexp_seq_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_EXPO = 4'b0100,
    S_FIN  = 4'b1000
  } mexp_state_e;

endpackage

// ===== design/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: a double step and an add step per multiplier bit.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  mm_step_t         step_i,
  input  logic             bit_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] m_i,
  output logic [WIDTH-1:0] r_o
);

  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] cur;
  logic [WIDTH:0]   x, sub;

  // Double or add, then one conditional subtract keeps the remainder below m.
  always_comb begin
    cur = step_i.first ? '0 : r_q;
    if (step_i.add) begin
      x = {1'b0, cur} + (bit_i ? {1'b0, a_i} : '0);
    end else begin
      x = {cur, 1'b0};
    end
    sub = x - {1'b0, m_i};
    r_d = (x >= {1'b0, m_i}) ? sub[WIDTH-1:0] : x[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_d;

endmodule

// ===== design/mexp_ctrl.sv =====
// Sequencer: state machine, multiplier bit counter and exponent bit counter.
module mexp_ctrl import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_fire_i,
  input  logic      bypass_i,
  input  logic      out_free_i,
  output mexp_seq_t seq_o
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] TOP = CW'(WIDTH - 1);

  mexp_state_e   state_q, state_d;
  logic [CW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CW-1:0] exp_cnt_q, exp_cnt_d;
  logic          phase_q, phase_d;
  logic          mul_last;

  assign mul_last = phase_q && (bit_cnt_q == '0);

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    exp_cnt_d = exp_cnt_q;
    phase_d   = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          phase_d   = 1'b0;
          bit_cnt_d = TOP;
          state_d   = bypass_i ? S_FIN : S_LOAD;
        end
      end
      S_LOAD, S_EXPO: begin
        phase_d = !phase_q;
        if (phase_q) begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
        if (mul_last) begin
          bit_cnt_d = TOP;
          if (state_q == S_LOAD) begin
            exp_cnt_d = TOP;
            state_d   = S_EXPO;
          end else if (exp_cnt_q == '0) begin
            state_d = S_FIN;
          end else begin
            exp_cnt_d = exp_cnt_q - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_cnt_q <= '0;
      exp_cnt_q <= '0;
      phase_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      exp_cnt_q <= exp_cnt_d;
      phase_q   <= phase_d;
    end
  end

  always_comb begin
    seq_o.idle       = (state_q == S_IDLE);
    seq_o.load       = (state_q == S_LOAD);
    seq_o.expo       = (state_q == S_EXPO);
    seq_o.fin        = (state_q == S_FIN);
    seq_o.mul_last   = mul_last;
    seq_o.step.first = !phase_q && (bit_cnt_q == TOP);
    seq_o.step.add   = phase_q;
  end

endmodule

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block.
// Computes base^exponent mod modulus by right-to-left square and multiply over the
// low WIDTH bits of each input field. A transaction is taken only while the block is
// idle. The base is first reduced modulo the modulus, then for each of the WIDTH
// exponent bits two bit-serial modular multipliers (running product times square,
// and square times square) walk the square's bits MSB first, one double step and one
// add step per bit. A zero modulus returns error = 1 with result 0 and a zero exponent
// returns 1 unreduced; both skip the reduction and the exponent scan and go straight
// to the finish state. The result sits in an output register, so the next
// transaction is accepted while it waits to be taken.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mexp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mexp_out_t out_data_o
);

  mexp_seq_t        seq;
  logic             in_fire;
  logic             out_free;
  logic             bypass;
  logic             mul_en;
  logic [WIDTH-1:0] m_q, e_q, bsh_q, sq_q, acc_q;
  logic             mzero_q, ezero_q;
  logic [WIDTH-1:0] prod;
  logic [WIDTH-1:0] sqr;
  logic [WIDTH-1:0] sq_a;
  logic             out_valid_q;
  mexp_out_t        out_q;

  assign in_ready_o = seq.idle;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  // Skip the arithmetic for a zero modulus or a zero exponent.
  assign bypass     = (in_data_i.modulus[WIDTH-1:0] == '0) ||
                      (in_data_i.exponent[WIDTH-1:0] == '0);
  assign mul_en     = seq.load || seq.expo;

  mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .bypass_i   (bypass),
    .out_free_i (out_free),
    .seq_o      (seq)
  );

  // Running product times current square.
  mexp_mulmod #(.WIDTH(WIDTH)) u_mul_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (seq.expo),
    .step_i (seq.step),
    .bit_i  (bsh_q[WIDTH-1]),
    .a_i    (acc_q),
    .m_i    (m_q),
    .r_o    (prod)
  );

  // Square times square; during the load phase, one times base, which reduces the base.
  assign sq_a = seq.load ? WIDTH'(1) : sq_q;

  mexp_mulmod #(.WIDTH(WIDTH)) u_mul_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .step_i (seq.step),
    .bit_i  (bsh_q[WIDTH-1]),
    .a_i    (sq_a),
    .m_i    (m_q),
    .r_o    (sqr)
  );

  // Operand registers: load on acceptance, shift the multiplier bits out MSB first,
  // and commit products at the end of each multiply.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_q     <= in_data_i.modulus[WIDTH-1:0];
      e_q     <= in_data_i.exponent[WIDTH-1:0];
      bsh_q   <= in_data_i.base[WIDTH-1:0];
      mzero_q <= (in_data_i.modulus[WIDTH-1:0] == '0);
      ezero_q <= (in_data_i.exponent[WIDTH-1:0] == '0);
    end else if (mul_en) begin
      if (seq.mul_last) begin
        // New square becomes both operand and multiplier bit stream.
        sq_q  <= sqr;
        bsh_q <= sqr;
        if (seq.load) begin
          acc_q <= WIDTH'(1);
        end else begin
          if (e_q[0]) begin
            acc_q <= prod;
          end
          e_q <= e_q >> 1;
        end
      end else if (seq.step.add) begin
        bsh_q <= {bsh_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  // Output register: fill when the sequencer finishes, drain on handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq.fin && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.fin && out_free) begin
      out_q.error <= mzero_q;
      if (mzero_q) begin
        out_q.result <= '0;
      end else if (ezero_q) begin
        out_q.result <= FIELD_W'(1);
      end else begin
        out_q.result <= FIELD_W'(acc_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result appears only from the finish state.
  a_rose_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(seq.fin))
    else $error("result presented outside the finish state");

  // An error result always carries zero.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.result == '0))
    else $error("error result is not zero");

  // The block goes busy right after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // The square stays reduced throughout the exponent scan.
  a_square_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq.expo |-> (sq_q < m_q))
    else $error("square not reduced modulo the modulus");

endmodule

// ===== tb/mexp_checker.sv =====
// Scoreboard for the modular exponentiation block: predicts every transaction and checks results.
`timescale 1ns / 100ps
module mexp_checker import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  mexp_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  mexp_out_t   out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned checked_count_o,
  output int unsigned pending_o
);

  mexp_out_t expected_q[$];

  // Right-to-left square and multiply on 64-bit words; every product of two
  // reduced WIDTH-bit values fits.
  function automatic mexp_out_t powmod_predict(mexp_in_t op);
    logic [63:0] mask;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] sq;
    mexp_out_t   res;
    mask = (64'd1 << WIDTH) - 64'd1;
    b    = {32'd0, op.base} & mask;
    e    = {32'd0, op.exponent} & mask;
    m    = {32'd0, op.modulus} & mask;
    res  = '0;
    if (m == 64'd0) begin
      res.error = 1'b1;
    end else if (e == 64'd0) begin
      // no reduction here: a modulus of one still returns one
      res.result = FIELD_W'(1);
    end else begin
      acc = 64'd1;
      sq  = b % m;
      for (int i = 0; i < WIDTH; i++) begin
        if (e[i]) begin
          acc = (acc * sq) % m;
        end
        sq = (sq * sq) % m;
      end
      res.result = acc[FIELD_W-1:0];
    end
    return res;
  endfunction

  initial begin
    mismatch_count_o = 0;
    checked_count_o  = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mexp_out_t want;
    if (rst_ni) begin
      // retire the oldest expectation before queuing a new one
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing outstanding: result %h error %b",
                 out_data_i.result, out_data_i.error);
          mismatch_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_count_o++;
          if (out_data_i.result !== want.result) begin
            $error("result mismatch: expected %h, actual %h", want.result, out_data_i.result);
            mismatch_count_o++;
          end
          if (out_data_i.error !== want.error) begin
            $error("error mismatch: expected %b, actual %b", want.error, out_data_i.error);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(powmod_predict(in_data_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, clocking and verdict for the modular exponentiation block.
`timescale 1ns / 100ps
module tb_top;
  import mexp_pkg::*;

  localparam int          WIDTH          = 32;
  // ITEM_CYCLES covers one full transaction inside the block.
  localparam int          ITEM_CYCLES    = 2 * WIDTH * (WIDTH + 1) + 2;
  localparam int          RANDOM_ITEMS   = 270;
  localparam int          RX_HOLD_CYCLES = 3 * ITEM_CYCLES + 500;
  // Limit set at several times the slowest legal run.
  localparam int unsigned CYCLE_LIMIT    = 5_000_000;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mexp_in_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mexp_out_t out_data;

  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned pending;

  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned zero_mod_count = 0;
  int unsigned zero_exp_count = 0;
  int unsigned held_cycles = 0;

  // Handshake between the stimulus process and the receiver process.
  bit rx_hold_req = 1'b0;
  bit rx_steady   = 1'b0;
  bit tx_steady   = 1'b0;

  always #5 clk_i = ~clk_i;

  modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  mexp_checker #(.WIDTH(WIDTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .checked_count_o (checked_count),
    .pending_o       (pending)
  );

  // Abort a hung run: nothing legal takes this long.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: mostly ready, with short and occasional long stalls, one steady
  // stretch, and a single long hold-off that backs the block up into its input.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned roll;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rx_hold_req && !hold_done) begin
          hold_done = 1'b1;
          hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          held_cycles++;
          out_ready <= 1'b0;
        end else if (stall_left != 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if (!rx_steady && $urandom_range(0, 9) == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
              stall_left = $urandom_range(1, 3);
            end else if (roll < 95) begin
              stall_left = $urandom_range(4, 20);
            end else begin
              stall_left = $urandom_range(50, 300);
            end
          end
        end
      end
    end
  end

  // Idle for gap cycles, then offer one transaction and hold it until accepted.
  // Return at the accepting edge so a zero gap keeps valid high.
  task automatic drive_operands(input mexp_in_t op, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_count++;
    if (op.modulus == '0) begin
      zero_mod_count++;
    end else if (op.exponent == '0) begin
      zero_exp_count++;
    end
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic mexp_in_t pack_operands(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    mexp_in_t op;
    op.base     = b;
    op.exponent = e;
    op.modulus  = m;
    return op;
  endfunction

  function automatic mexp_in_t random_operands();
    mexp_in_t    op;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      op.base = '0;
    end else if (roll < 8) begin
      op.base = '1;
    end else if (roll < 16) begin
      op.base = $urandom_range(1, 15);
    end else begin
      op.base = $urandom();
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      op.exponent = '0;
    end else if (roll < 15) begin
      op.exponent = $urandom_range(1, 16);
    end else if (roll < 20) begin
      op.exponent = '1;
    end else if (roll < 30) begin
      op.exponent = 32'd1 << $urandom_range(0, 31);
    end else begin
      op.exponent = $urandom();
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      op.modulus = '0;
    end else if (roll < 8) begin
      op.modulus = 32'd1;
    end else if (roll < 18) begin
      op.modulus = $urandom_range(2, 255);
    end else if (roll < 21) begin
      op.modulus = '1;
    end else if (roll < 24) begin
      op.modulus = 32'h8000_0000;
    end else begin
      op.modulus = $urandom();
    end
    return op;
  endfunction

  initial begin
    int unsigned gap;
    int unsigned roll;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero modulus, zero exponent, unit modulus and field extremes.
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000), 0);
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000), 0);
    drive_operands(pack_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0001), 1);
    drive_operands(pack_operands(32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF), 0);
    drive_operands(pack_operands(32'h0000_0007, 32'h0000_0001, 32'h0000_0001), 2);
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001), 0);
    drive_operands(pack_operands(32'h0000_0000, 32'h0000_0005, 32'h0000_0007), 0);
    drive_operands(pack_operands(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 3);
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFB), 0);
    drive_operands(pack_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB), 1);
    drive_operands(pack_operands(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8), 0);
    drive_operands(pack_operands(32'h0000_0003, 32'h8000_0000, 32'hFFFF_FFC5), 0);
    drive_operands(pack_operands(32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_000D), 2);
    drive_operands(pack_operands(32'h0000_0005, 32'h0000_0007, 32'h0000_0002), 0);
    drive_operands(pack_operands(32'h7FFF_FFFF, 32'h5555_5555, 32'h8000_0000), 0);
    drive_operands(pack_operands(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h8000_0001), 0);
    drive_operands(pack_operands(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003), 4);
    drive_operands(pack_operands(32'h0001_0000, 32'h0000_0002, 32'hFFFF_FFFF), 0);

    // Pause until the directed batch has fully drained.
    wait_drained();

    // Random: request the long output hold-off at once so the block fills up.
    rx_hold_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Run a stretch with no idling on either side.
      tx_steady = (i >= 120 && i < 160);
      rx_steady = tx_steady;
      if (i == 200) begin
        wait_drained();
      end
      if (tx_steady) begin
        gap = 0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          gap = 0;
        end else if (roll < 90) begin
          gap = $urandom_range(1, 4);
        end else if (roll < 98) begin
          gap = $urandom_range(5, 40);
        end else begin
          gap = $urandom_range(300, 2500);
        end
      end
      drive_operands(random_operands(), gap);
    end
    rx_steady = 1'b0;

    // Drain, then give the block one more item time to show any stray result.
    wait_drained();
    repeat (ITEM_CYCLES + 100) @(posedge clk_i);

    $display("Sent %0d operand sets (%0d zero modulus, %0d zero exponent), checked %0d results",
             sent_count, zero_mod_count, zero_exp_count, checked_count);
    $display("Output held off for %0d cycles in one stretch, %0d mismatches, %0d outstanding",
             held_cycles, mismatch_count, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
